[rtl/core/cpcr_pkg.sv]
// shared types and constants for the circle pair collision resolver
`timescale 1ns / 1ps
`default_nettype none
package cpcr_pkg;

	localparam int unsigned POS_W  = 16;
	localparam int unsigned RAD_W  = 12;
	localparam int unsigned RSUM_W = 13;
	localparam int unsigned D2_W   = 26;
	localparam int unsigned MAG_W  = 14;
	localparam int unsigned ROOT_W = 13;
	localparam int unsigned SREM_W = 16;
	localparam int unsigned DREM_W = 15;
	localparam int unsigned NUM_W  = 26;
	localparam int unsigned QUO_W  = 13;

	typedef struct packed {
		logic signed [POS_W-1:0] a_pos_x;
		logic signed [POS_W-1:0] a_pos_y;
		logic signed [POS_W-1:0] b_pos_x;
		logic signed [POS_W-1:0] b_pos_y;
		logic        [RAD_W-1:0] a_radius;
		logic        [RAD_W-1:0] b_radius;
		logic signed [POS_W-1:0] a_vel_x;
		logic signed [POS_W-1:0] a_vel_y;
		logic signed [POS_W-1:0] b_vel_x;
		logic signed [POS_W-1:0] b_vel_y;
	} in_t;

	typedef struct packed {
		logic                    hit;
		logic signed [POS_W-1:0] new_a_pos_x;
		logic signed [POS_W-1:0] new_a_pos_y;
		logic signed [POS_W-1:0] new_b_pos_x;
		logic signed [POS_W-1:0] new_b_pos_y;
		logic signed [POS_W-1:0] new_a_vel_x;
		logic signed [POS_W-1:0] new_a_vel_y;
		logic signed [POS_W-1:0] new_b_vel_x;
		logic signed [POS_W-1:0] new_b_vel_y;
	} out_t;

	// classified pair handed from front to back
	typedef struct packed {
		in_t                it;
		logic               hit;
		logic               mv;
		logic               sdx;
		logic               sdy;
		logic [MAG_W-1:0]   mdx;
		logic [MAG_W-1:0]   mdy;
		logic [RSUM_W-1:0]  rsum;
		logic [D2_W-1:0]    d2;
	} fr_t;

	// working state of one back pipeline stage
	typedef struct packed {
		fr_t                f;
		logic [D2_W-1:0]    rad;
		logic [SREM_W-1:0]  srem;
		logic [ROOT_W-1:0]  root;
		logic [MAG_W-1:0]   dv;
		logic [NUM_W-1:0]   nx;
		logic [NUM_W-1:0]   ny;
		logic [DREM_W-1:0]  drx;
		logic [DREM_W-1:0]  dry;
		logic [QUO_W-1:0]   qx;
		logic [QUO_W-1:0]   qy;
	} bk_t;

endpackage
`default_nettype wire

[rtl/core/cpcr_front.sv]
// front: distance and overlap test, three stages
`timescale 1ns / 1ps
`default_nettype none
module cpcr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cpcr_pkg::in_t in_data,
	input  wire logic          q_full,
	output logic               push,
	output cpcr_pkg::fr_t      push_data
);

	logic                 v_s1, v_s2, v_s3, en;
	cpcr_pkg::in_t        it_s1, it_s2;
	logic signed [16:0]   dx_s1, dy_s1, dx_s2, dy_s2;
	logic [12:0]          rsum_s1, rsum_s2;
	logic [31:0]          sqx_s2, sqy_s2;
	logic [25:0]          rs2_s2;
	logic signed [33:0]   px, py;
	logic [25:0]          pr;
	logic [32:0]          d2;
	logic [16:0]          ax, ay;
	cpcr_pkg::fr_t        fr_s3;

	assign en        = !v_s3 || !q_full;
	assign in_ready  = en;
	assign push      = v_s3 && !q_full;
	assign push_data = fr_s3;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pr = rsum_s1 * rsum_s1;
	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign ax = dx_s2[16] ? 17'(-dx_s2) : 17'(dx_s2);
	assign ay = dy_s2[16] ? 17'(-dy_s2) : 17'(dy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= in_data;
			dx_s1   <= {in_data.b_pos_x[15], in_data.b_pos_x}
				- {in_data.a_pos_x[15], in_data.a_pos_x};
			dy_s1   <= {in_data.b_pos_y[15], in_data.b_pos_y}
				- {in_data.a_pos_y[15], in_data.a_pos_y};
			rsum_s1 <= {1'b0, in_data.a_radius} + {1'b0, in_data.b_radius};
			it_s2   <= it_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			rsum_s2 <= rsum_s1;
			sqx_s2  <= px[31:0];
			sqy_s2  <= py[31:0];
			rs2_s2  <= pr;
			fr_s3.it   <= it_s2;
			fr_s3.hit  <= d2 < {7'b0, rs2_s2};
			fr_s3.mv   <= (d2 < {7'b0, rs2_s2}) && (d2 != 33'd0);
			fr_s3.sdx  <= dx_s2[16];
			fr_s3.sdy  <= dy_s2[16];
			fr_s3.mdx  <= ax[13:0];
			fr_s3.mdy  <= ay[13:0];
			fr_s3.rsum <= rsum_s2;
			fr_s3.d2   <= d2[25:0];
		end
	end

endmodule
`default_nettype wire

[rtl/core/cpcr_queue.sv]
// four entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cpcr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cpcr_pkg::fr_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output cpcr_pkg::fr_t      pop_data
);

	cpcr_pkg::fr_t mem_q [4];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    cnt_q;

	assign full     = cnt_q == 3'd4;
	assign empty    = cnt_q == 3'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

[rtl/core/cpcr_back.sv]
// back: square root, scaling and division pipeline, output register
`timescale 1ns / 1ps
`default_nettype none
module cpcr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire cpcr_pkg::fr_t pop_data,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cpcr_pkg::out_t     out_data
);

	localparam int NSQ = 13;
	localparam int MUL = NSQ + 1;
	localparam int NST = MUL + 13 + 1;

	cpcr_pkg::bk_t  st_q [NST];
	cpcr_pkg::bk_t  nxt  [NST];
	logic [NST-1:0] v_q;
	logic           en;
	cpcr_pkg::out_t res;

	function automatic logic [15:0] sat16(input logic signed [17:0] v);
		logic [15:0] r;
		if (v > 18'sd32767) r = 16'h7fff;
		else if (v < -18'sd32768) r = 16'h8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [17:0] shift_of(input logic s, input logic [12:0] q,
			input logic m);
		logic signed [17:0] r;
		r = s ? -$signed({5'b0, q}) : $signed({5'b0, q});
		return m ? r : 18'sd0;
	endfunction

	assign en  = !out_valid || out_ready;
	assign pop = en && !empty;

	always_comb begin
		logic [15:0] rr, tr;
		logic [26:0] px, py;
		logic [14:0] ex, ey;
		nxt[0]      = st_q[0];
		nxt[0].f    = pop_data;
		nxt[0].rad  = pop_data.d2;
		nxt[0].srem = '0;
		nxt[0].root = '0;
		for (int k = 1; k < NST; k++) begin
			nxt[k] = st_q[k-1];
			if (k <= NSQ) begin
				// one root bit per stage
				rr = {st_q[k-1].srem[13:0], st_q[k-1].rad[25:24]};
				tr = {1'b0, st_q[k-1].root, 2'b01};
				nxt[k].rad = {st_q[k-1].rad[23:0], 2'b00};
				if (rr >= tr) begin
					nxt[k].srem = rr - tr;
					nxt[k].root = {st_q[k-1].root[11:0], 1'b1};
				end else begin
					nxt[k].srem = rr;
					nxt[k].root = {st_q[k-1].root[11:0], 1'b0};
				end
			end else if (k == MUL) begin
				px = st_q[k-1].f.mdx * (st_q[k-1].f.rsum - st_q[k-1].root);
				py = st_q[k-1].f.mdy * (st_q[k-1].f.rsum - st_q[k-1].root);
				nxt[k].nx  = px[25:0];
				nxt[k].ny  = py[25:0];
				nxt[k].dv  = {st_q[k-1].root, 1'b0};
				nxt[k].drx = {2'b0, px[25:13]};
				nxt[k].dry = {2'b0, py[25:13]};
				nxt[k].qx  = '0;
				nxt[k].qy  = '0;
			end else begin
				// one quotient bit per stage, both lanes
				ex = {st_q[k-1].drx[13:0], st_q[k-1].nx[12]};
				ey = {st_q[k-1].dry[13:0], st_q[k-1].ny[12]};
				nxt[k].nx = {st_q[k-1].nx[24:0], 1'b0};
				nxt[k].ny = {st_q[k-1].ny[24:0], 1'b0};
				if (ex >= {1'b0, st_q[k-1].dv}) begin
					nxt[k].drx = ex - {1'b0, st_q[k-1].dv};
					nxt[k].qx  = {st_q[k-1].qx[11:0], 1'b1};
				end else begin
					nxt[k].drx = ex;
					nxt[k].qx  = {st_q[k-1].qx[11:0], 1'b0};
				end
				if (ey >= {1'b0, st_q[k-1].dv}) begin
					nxt[k].dry = ey - {1'b0, st_q[k-1].dv};
					nxt[k].qy  = {st_q[k-1].qy[11:0], 1'b1};
				end else begin
					nxt[k].dry = ey;
					nxt[k].qy  = {st_q[k-1].qy[11:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		logic signed [17:0] sx, sy;
		cpcr_pkg::fr_t f;
		f  = st_q[NST-1].f;
		sx = shift_of(f.sdx, st_q[NST-1].qx, f.mv);
		sy = shift_of(f.sdy, st_q[NST-1].qy, f.mv);
		res.hit         = f.hit;
		res.new_a_pos_x = sat16({{2{f.it.a_pos_x[15]}}, f.it.a_pos_x} - sx);
		res.new_a_pos_y = sat16({{2{f.it.a_pos_y[15]}}, f.it.a_pos_y} - sy);
		res.new_b_pos_x = sat16({{2{f.it.b_pos_x[15]}}, f.it.b_pos_x} + sx);
		res.new_b_pos_y = sat16({{2{f.it.b_pos_y[15]}}, f.it.b_pos_y} + sy);
		res.new_a_vel_x = f.hit ? f.it.b_vel_x : f.it.a_vel_x;
		res.new_a_vel_y = f.hit ? f.it.b_vel_y : f.it.a_vel_y;
		res.new_b_vel_x = f.hit ? f.it.a_vel_x : f.it.b_vel_x;
		res.new_b_vel_y = f.hit ? f.it.a_vel_y : f.it.b_vel_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q       <= {v_q[NST-2:0], !empty};
			out_valid <= v_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) st_q[k] <= nxt[k];
			out_data <= res;
		end
	end

endmodule
`default_nettype wire

[rtl/core/circle_pair_collision_resolve_unit.sv]
// top level of the circle pair collision resolver
`timescale 1ns / 1ps
`default_nettype none
// Accepts one circle pair per cycle while in_ready is high and returns one
// result per pair, in order. An accepted pair passes through three front
// stages for the distance test, a four-entry queue, and a back pipeline of an
// input stage, 13 square root stages, one scaling multiply stage, 13 divider
// stages and the output register. The front and back stall independently.
module circle_pair_collision_resolve_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire cpcr_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output cpcr_pkg::out_t      out_data
);

	logic          push, full, pop, empty;
	cpcr_pkg::fr_t push_data, pop_data;

	cpcr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_full(full), .push(push), .push_data(push_data)
	);

	cpcr_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .empty(empty), .pop_data(pop_data)
	);

	cpcr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.empty(empty), .pop_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
`default_nettype wire

[tb/tb_circle_pair_collision_resolve_unit.sv]
// testbench for the circle pair collision resolver: random and corner pairs against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_circle_pair_collision_resolve_unit;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cpcr_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	cpcr_pkg::out_t out_data;

	circle_pair_collision_resolve_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	cpcr_pkg::in_t pending_pairs[$];
	cpcr_pkg::out_t resolved_q[$];
	int mismatches = 0;
	bit stim_done = 0;
	bit calm = 0;
	int hold_off = 0;
	longint cycles = 0;

	// handshake seen at the last rising edge
	logic in_ready_s;

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task automatic add_pair(cpcr_pkg::in_t p);
		pending_pairs = {pending_pairs, p};
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic cpcr_pkg::out_t resolve_pair(cpcr_pkg::in_t p);
		cpcr_pkg::out_t r;
		longint ax, ay, bx, by, dx, dy, rsum, root_d, ovl, sx, sy;
		longint unsigned d2;
		logic hit;
		ax = p.a_pos_x; ay = p.a_pos_y; bx = p.b_pos_x; by = p.b_pos_y;
		dx = bx - ax;
		dy = by - ay;
		d2 = dx * dx + dy * dy;
		rsum = longint'(p.a_radius) + longint'(p.b_radius);
		hit = d2 < rsum * rsum;
		if (hit && d2 != 0) begin
			root_d = int_sqrt(d2);
			ovl = rsum - root_d;
			sx = (dx * ovl) / (2 * root_d);
			sy = (dy * ovl) / (2 * root_d);
			ax -= sx; ay -= sy; bx += sx; by += sy;
		end
		r.hit = hit;
		r.new_a_pos_x = clamp16(ax);
		r.new_a_pos_y = clamp16(ay);
		r.new_b_pos_x = clamp16(bx);
		r.new_b_pos_y = clamp16(by);
		r.new_a_vel_x = hit ? p.b_vel_x : p.a_vel_x;
		r.new_a_vel_y = hit ? p.b_vel_y : p.a_vel_y;
		r.new_b_vel_x = hit ? p.a_vel_x : p.b_vel_x;
		r.new_b_vel_y = hit ? p.a_vel_y : p.b_vel_y;
		return r;
	endfunction

	function automatic cpcr_pkg::in_t rand_pair();
		cpcr_pkg::in_t p;
		logic [191:0] raw;
		int k;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(cpcr_pkg::in_t)-1:0];
		k = $urandom_range(0, 9);
		// mostly near pairs so that separation math gets exercised
		if (k < 6) begin
			p.b_pos_x = p.a_pos_x + 16'($signed($urandom_range(0, 4000)) - 2000);
			p.b_pos_y = p.a_pos_y + 16'($signed($urandom_range(0, 4000)) - 2000);
			if (k == 0) p.b_pos_x = p.a_pos_x;
			if (k == 1) begin
				p.b_pos_x = p.a_pos_x;
				p.b_pos_y = p.a_pos_y;
			end
		end else if (k == 6) begin
			p.a_radius = 12'($urandom_range(0, 3));
			p.b_radius = 12'($urandom_range(0, 3));
			p.b_pos_x = p.a_pos_x + 16'($signed($urandom_range(0, 6)) - 3);
			p.b_pos_y = p.a_pos_y + 16'($signed($urandom_range(0, 6)) - 3);
		end
		return p;
	endfunction

	function automatic cpcr_pkg::in_t mk(int ax, int ay, int bx, int by, int ra, int rb);
		cpcr_pkg::in_t p;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(cpcr_pkg::in_t)-1:0];
		p.a_pos_x = 16'(ax); p.a_pos_y = 16'(ay); p.b_pos_x = 16'(bx); p.b_pos_y = 16'(by);
		p.a_radius = 12'(ra); p.b_radius = 12'(rb);
		return p;
	endfunction

	initial begin
		cpcr_pkg::in_t p;
		add_pair(mk(0, 0, 100, 0, 40, 40));
		add_pair(mk(0, 0, 80, 0, 40, 40));
		add_pair(mk(0, 0, 79, 0, 40, 40));
		add_pair(mk(5, 5, 5, 5, 10, 0));
		add_pair(mk(5, 5, 5, 5, 0, 0));
		add_pair(mk(0, 0, 0, 0, 0, 0));
		add_pair(mk(-32768, -32768, -32768, -32768, 4095, 4095));
		add_pair(mk(32767, 32767, 32767, 32767, 4095, 4095));
		add_pair(mk(32760, 32760, 32767, 32767, 4095, 4095));
		add_pair(mk(-32768, -32768, -32760, -32767, 4095, 4095));
		add_pair(mk(-32768, 0, 32767, 0, 4095, 4095));
		add_pair(mk(0, -32768, 0, 32767, 4095, 4095));
		add_pair(mk(32767, 0, -32768, 0, 4095, 4095));
		add_pair(mk(0, 0, 1, 0, 1, 0));
		add_pair(mk(0, 0, 1, 1, 1, 1));
		add_pair(mk(100, -100, -100, 100, 4095, 0));
		add_pair(mk(0, 0, -3, 4, 3, 3));
		add_pair(mk(0, 0, 3, -4, 2, 2));
		p = mk(0, 0, 0, 0, 4095, 4095);
		p.a_vel_x = 16'sh7fff; p.a_vel_y = 16'sh8000;
		p.b_vel_x = 16'sh8000; p.b_vel_y = 16'sh7fff;
		add_pair(p);
		repeat (1800) add_pair(rand_pair());
		stim_done = 1;
	end

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready_s) begin
				if (pending_pairs.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
					in_data <= pending_pairs.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end else if (!in_valid && pending_pairs.size() > 0
					&& (calm || $urandom_range(0, 99) >= 22)) begin
				in_data <= pending_pairs.pop_front();
				in_valid <= 1;
			end
		end
	end

	always @(posedge clk) in_ready_s <= in_ready;

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_off > 0) begin
			out_ready <= 0;
		end else begin
			out_ready <= calm || $urandom_range(0, 99) >= 22;
		end
	end

	// long receiver stall and a stretch with no idling
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 600) hold_off <= 200;
		else if (hold_off > 0) hold_off <= hold_off - 1;
		calm <= (cycles >= 1500 && cycles < 2500);
	end

	// predict at input acceptance, check at output acceptance
	always @(posedge clk) begin
		cpcr_pkg::out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) resolved_q = {resolved_q, resolve_pair(in_data)};
			if (out_valid && out_ready) begin
				if (resolved_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transaction %h", out_data);
				end else begin
					want = resolved_q.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h", want, out_data);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (stim_done && pending_pairs.size() == 0 && !in_valid);
		wait (resolved_q.size() == 0);
		repeat (64) @(posedge clk);
		if (mismatches == 0 && resolved_q.size() == 0)
			$display("[circle_pair_collision_resolve_unit] OK");
		else
			$display("[circle_pair_collision_resolve_unit] ERROR");
		$finish;
	end

	initial begin
		wait (cycles >= 200000);
		$display("[circle_pair_collision_resolve_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
rtl/core/cpcr_pkg.sv
rtl/core/cpcr_front.sv
rtl/core/cpcr_queue.sv
rtl/core/cpcr_back.sv
rtl/core/circle_pair_collision_resolve_unit.sv
tb/tb_circle_pair_collision_resolve_unit.sv
